### sv/art_pkg.sv
// art_pkg: shared types and constants for the ack retry tracker
// holds the item structs, entry layout, command and event codes, fsm states
// no dependencies
package art_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// command codes
	localparam logic [1:0] CMD_TRACK = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_CHECK = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// event codes
	localparam logic [2:0] EV_TRACKED     = 3'd0;
	localparam logic [2:0] EV_FULL        = 3'd1;
	localparam logic [2:0] EV_DUPLICATE   = 3'd2;
	localparam logic [2:0] EV_ACK_MATCHED = 3'd3;
	localparam logic [2:0] EV_ACK_UNKNOWN = 3'd4;
	localparam logic [2:0] EV_RESEND      = 3'd5;
	localparam logic [2:0] EV_FAILURE     = 3'd6;
	localparam logic [2:0] EV_SCAN_DONE   = 3'd7;

	// register indexes
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_RETRIES = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] message_id;
		logic [2:0]  ack_exec_status;
		logic [31:0] now_time;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [31:0] event_id;
		logic [3:0]  retry_number;
		logic [2:0]  exec_status;
		logic        changed;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] timeout_ms;
		logic [3:0]  max_retries;
	} cfg_t;

	typedef struct packed {
		logic [31:0] id;
		logic        waiting;
		logic [3:0]  retries;
		logic [31:0] sent_time;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ctrl_state_t;

endpackage

### sv/art_cfg_regs.sv
// art_cfg_regs: apb register block for timeout and retry budget
// depends on art_pkg
module art_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output art_pkg::cfg_t     cfg
);

	art_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms  <= 32'd1000;
			cfg_q.max_retries <= 4'd3;
		end else if (wr_en) begin
			case (paddr[2])
				art_pkg::REG_TIMEOUT: cfg_q.timeout_ms  <= pwdata;
				art_pkg::REG_RETRIES: cfg_q.max_retries <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[2])
			art_pkg::REG_TIMEOUT: prdata = cfg_q.timeout_ms;
			art_pkg::REG_RETRIES: prdata = {28'd0, cfg_q.max_retries};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

### sv/art_entry_ram.sv
// art_entry_ram: entry table memory, one write and one registered read port
// depends on art_pkg
module art_entry_ram (
	input  logic                      clk,
	input  art_pkg::ram_wr_t          wr,
	input  logic                      rd_en,
	input  logic [art_pkg::IDX_W-1:0] rd_addr,
	output art_pkg::entry_t           rd_data
);

	art_pkg::entry_t mem [art_pkg::TABLE_DEPTH];
	art_pkg::entry_t rd_data_q;

	assign rd_data = rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

### sv/art_ctrl.sv
// art_ctrl: command sequencer with the shared id / age compare unit
// walks the entry memory one entry per cycle; depends on art_pkg
module art_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  art_pkg::req_t             req,
	input  art_pkg::cfg_t             cfg,
	output logic                      busy,
	output logic                      rsp_valid,
	output art_pkg::rsp_t             rsp,
	output art_pkg::ram_wr_t          ram_wr,
	output logic                      ram_rd_en,
	output logic [art_pkg::IDX_W-1:0] ram_rd_addr,
	input  art_pkg::entry_t           ram_rd_data
);

	art_pkg::ctrl_state_t state_q, state_d;

	art_pkg::req_t             req_q;
	logic [art_pkg::CNT_W-1:0] count_q;
	logic [art_pkg::CNT_W-1:0] ptr_q;
	logic                      v_s1;
	logic [art_pkg::IDX_W-1:0] idx_s1;
	logic                      found_q;
	logic                      chg_q;
	logic                      rsp_valid_q;
	art_pkg::rsp_t             rsp_q;

	logic          accept;
	logic          issue;
	logic          id_match;
	logic          timed_out;
	logic          may_retry;
	logic [31:0]   age;
	logic          hit_stop;
	logic          scan_end;
	logic          emit_en;
	art_pkg::rsp_t emit;
	logic          append;
	logic          full;

	assign accept = start && (state_q == art_pkg::ST_IDLE) &&
		(req.command != art_pkg::CMD_NONE);
	assign busy      = (state_q != art_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign full      = (count_q == art_pkg::CNT_W'(art_pkg::TABLE_DEPTH));

	// shared compare unit on the entry just read
	assign age       = req_q.now_time - ram_rd_data.sent_time;
	assign id_match  = (ram_rd_data.id == req_q.message_id);
	assign timed_out = (age >= cfg.timeout_ms);
	assign may_retry = (ram_rd_data.retries < cfg.max_retries);

	// walk control
	assign issue    = (ptr_q < count_q);
	assign hit_stop = v_s1 && id_match && (req_q.command != art_pkg::CMD_CHECK);
	assign scan_end = hit_stop || (!v_s1 && !issue);
	assign append   = (req_q.command == art_pkg::CMD_TRACK) && !full && !found_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			art_pkg::ST_IDLE:   if (accept)   state_d = art_pkg::ST_SCAN;
			art_pkg::ST_SCAN:   if (scan_end) state_d = art_pkg::ST_FINISH;
			art_pkg::ST_FINISH: state_d = art_pkg::ST_IDLE;
			default:            state_d = art_pkg::ST_IDLE;
		endcase
	end

	// outputs: memory access and result items
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = ptr_q[art_pkg::IDX_W-1:0];
		ram_wr.en   = 1'b0;
		ram_wr.addr = idx_s1;
		ram_wr.data = ram_rd_data;
		emit_en     = 1'b0;
		emit        = '0;
		case (state_q)
			art_pkg::ST_SCAN: begin
				ram_rd_en = issue;
				if (v_s1) begin
					if (req_q.command == art_pkg::CMD_ACK && id_match) begin
						ram_wr.en           = 1'b1;
						ram_wr.data.waiting = 1'b0;
					end else if (req_q.command == art_pkg::CMD_CHECK &&
							ram_rd_data.waiting && timed_out) begin
						ram_wr.en     = 1'b1;
						emit_en       = 1'b1;
						emit.event_id = ram_rd_data.id;
						if (may_retry) begin
							ram_wr.data.retries   = ram_rd_data.retries + 4'd1;
							ram_wr.data.sent_time = req_q.now_time;
							emit.event_kind       = art_pkg::EV_RESEND;
							emit.retry_number     = ram_rd_data.retries + 4'd1;
						end else begin
							ram_wr.data.waiting = 1'b0;
							emit.event_kind     = art_pkg::EV_FAILURE;
							emit.retry_number   = ram_rd_data.retries;
						end
					end
				end
			end
			art_pkg::ST_FINISH: begin
				emit_en   = 1'b1;
				emit.last = 1'b1;
				case (req_q.command)
					art_pkg::CMD_TRACK: begin
						emit.event_id = req_q.message_id;
						if (full) begin
							emit.event_kind = art_pkg::EV_FULL;
						end else if (found_q) begin
							emit.event_kind = art_pkg::EV_DUPLICATE;
						end else begin
							emit.event_kind       = art_pkg::EV_TRACKED;
							ram_wr.en             = 1'b1;
							ram_wr.addr           = count_q[art_pkg::IDX_W-1:0];
							ram_wr.data.id        = req_q.message_id;
							ram_wr.data.waiting   = 1'b1;
							ram_wr.data.retries   = 4'd0;
							ram_wr.data.sent_time = req_q.now_time;
						end
					end
					art_pkg::CMD_ACK: begin
						emit.event_id = req_q.message_id;
						if (found_q) begin
							emit.event_kind  = art_pkg::EV_ACK_MATCHED;
							emit.exec_status = req_q.ack_exec_status;
						end else begin
							emit.event_kind = art_pkg::EV_ACK_UNKNOWN;
						end
					end
					default: begin
						emit.event_kind = art_pkg::EV_SCAN_DONE;
						emit.changed    = chg_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= art_pkg::ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			chg_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= emit_en;
			if (accept) begin
				ptr_q   <= '0;
				v_s1    <= 1'b0;
				found_q <= 1'b0;
				chg_q   <= 1'b0;
			end else if (state_q == art_pkg::ST_SCAN) begin
				v_s1 <= issue && !scan_end;
				if (issue) begin
					ptr_q <= ptr_q + art_pkg::CNT_W'(1);
				end
				if (hit_stop) begin
					found_q <= 1'b1;
				end
				if (emit_en) begin
					chg_q <= 1'b1;
				end
			end else begin
				v_s1 <= 1'b0;
			end
			if (state_q == art_pkg::ST_FINISH && append) begin
				count_q <= count_q + art_pkg::CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= ptr_q[art_pkg::IDX_W-1:0];
		if (emit_en) begin
			rsp_q <= emit;
		end
	end

endmodule

### sv/ack_retry_tracker.sv
// ack_retry_tracker: top level of the acknowledgement / retry tracking table
// depends on art_pkg, art_cfg_regs, art_entry_ram, art_ctrl
//
// A command is taken when start is high and busy is low; busy then stays high
// while the table of up to 16 entries is walked one entry per cycle through a
// single-read-port entry memory and one shared id / age compare unit. A check
// walks every entry before its final item; track and ack stop early on the
// first id match. Each result item sits on rsp for exactly one cycle with
// rsp_valid high and must be taken then: the receiver cannot stall it. The
// final item of a command carries last = 1 and appears in the cycle busy
// falls. Command 3 is ignored. The table starts empty after reset with no
// clearing pass.
module ack_retry_tracker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  art_pkg::req_t req,
	output logic          busy,
	output logic          rsp_valid,
	output art_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	art_pkg::cfg_t             cfg;
	art_pkg::ram_wr_t          ram_wr;
	logic                      ram_rd_en;
	logic [art_pkg::IDX_W-1:0] ram_rd_addr;
	art_pkg::entry_t           ram_rd_data;

	// configuration registers
	art_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// entry table
	art_entry_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// sequencer and compare unit
	art_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req         (req),
		.cfg         (cfg),
		.busy        (busy),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.ram_wr      (ram_wr),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

endmodule

### sv/art_checker.sv
// art_checker: port-level checks on the ack retry tracker, bound to the top
// depends on art_pkg and ack_retry_tracker
module art_sva (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  art_pkg::req_t req,
	input  logic          busy,
	input  logic          rsp_valid,
	input  art_pkg::rsp_t rsp
);

	// a real command makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.command != art_pkg::CMD_NONE) |=> busy)
		else $error("command accepted but block not busy");

	// intermediate items only while busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> busy)
		else $error("intermediate item outside a command");

	// the end of a command always shows the final item
	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> rsp_valid && rsp.last)
		else $error("command ended without a final item");

	// nothing follows a final item in the next cycle
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |=> !rsp_valid)
		else $error("item right after a final item");

	// scan done is final and carries no id
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.event_kind == art_pkg::EV_SCAN_DONE) |->
		rsp.last && (rsp.event_id == 32'd0))
		else $error("malformed scan done item");

endmodule

bind ack_retry_tracker art_sva u_art_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.req       (req),
	.busy      (busy),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);
